### rtl/epr_pkg.sv
// ----------------------------------------------------------------------------
// epr_pkg: shared types and constants of the Euler point rotation block
// Holds the CORDIC arctangent table, fixed-point constants and register codes.
// ----------------------------------------------------------------------------
package epr_pkg;

  localparam int TrigFrac  = 24;
  localparam int TrigW     = 28;   // Q.24 working width for CORDIC
  localparam int AtanCount = 24;
  localparam int AngleW    = 16;

  localparam logic signed [TrigW-1:0] TrigGain = 28'sd10188014;
  localparam logic signed [TrigW-1:0] PiQ      = 28'sd52707179;
  localparam logic signed [TrigW-1:0] HalfPiQ  = 28'sd26353589;

  localparam logic [1:0] RegAngleX = 2'd0;
  localparam logic [1:0] RegAngleY = 2'd1;
  localparam logic [1:0] RegAngleZ = 2'd2;

  function automatic logic signed [TrigW-1:0] atan_lut(input logic [4:0] idx);
    logic signed [TrigW-1:0] v;
    case (idx)
      5'd0:  v = 28'sd13176795;
      5'd1:  v = 28'sd7778716;
      5'd2:  v = 28'sd4110060;
      5'd3:  v = 28'sd2086331;
      5'd4:  v = 28'sd1047214;
      5'd5:  v = 28'sd524117;
      5'd6:  v = 28'sd262123;
      5'd7:  v = 28'sd131069;
      default: begin
        if (idx < 5'd24) v = 28'sd65536 >>> (idx - 5'd8);
        else v = '0;
      end
    endcase
    return v;
  endfunction

endpackage

### rtl/epr_trig.sv
// ----------------------------------------------------------------------------
// epr_trig: iterative CORDIC sine/cosine
// One micro-rotation per cycle; result rounded to Q1.F and saturated.
// ----------------------------------------------------------------------------
module epr_trig #(
  parameter int COEF_WIDTH = 18,
  parameter int TRIG_STEPS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [15:0]           angle_i,
  output logic                         done_o,
  output logic signed [COEF_WIDTH-1:0] sin_o,
  output logic signed [COEF_WIDTH-1:0] cos_o
);
  import epr_pkg::*;

  localparam int Steps = (TRIG_STEPS < AtanCount) ? TRIG_STEPS : AtanCount;
  localparam int Shr   = TrigFrac - (COEF_WIDTH - 2);
  localparam logic signed [TrigW:0] CoefMax = (TrigW+1)'((64'sd1 <<< (COEF_WIDTH-1)) - 1);
  localparam logic signed [TrigW:0] CoefMin = -CoefMax - 1;

  logic signed [TrigW-1:0] x_q, y_q, z_q;
  logic                    neg_q, busy_q, done_q;
  logic [4:0]              step_q;
  logic signed [TrigW-1:0] z0, xs, ys;
  logic                    neg0;
  logic signed [TrigW:0]   xr, yr, xt, yt;

  always_comb begin
    z0   = TrigW'(angle_i) <<< 11;
    neg0 = 1'b0;
    if (z0 > HalfPiQ) begin
      z0 = z0 - PiQ; neg0 = 1'b1;
    end else if (z0 < -HalfPiQ) begin
      z0 = z0 + PiQ; neg0 = 1'b1;
    end
    xs = x_q >>> step_q;
    ys = y_q >>> step_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == 5'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q   <= TrigGain;
      y_q   <= '0;
      z_q   <= z0;
      neg_q <= neg0;
    end else if (busy_q) begin
      if (!z_q[TrigW-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_lut(step_q);
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_lut(step_q);
      end
    end
  end

  always_comb begin
    xt = neg_q ? -(TrigW+1)'(x_q) : (TrigW+1)'(x_q);
    yt = neg_q ? -(TrigW+1)'(y_q) : (TrigW+1)'(y_q);
    xr = (xt + ((TrigW+1)'(1) <<< (Shr-1))) >>> Shr;
    yr = (yt + ((TrigW+1)'(1) <<< (Shr-1))) >>> Shr;
    cos_o = (xr > CoefMax) ? CoefMax[COEF_WIDTH-1:0] :
            (xr < CoefMin) ? CoefMin[COEF_WIDTH-1:0] : xr[COEF_WIDTH-1:0];
    sin_o = (yr > CoefMax) ? CoefMax[COEF_WIDTH-1:0] :
            (yr < CoefMin) ? CoefMin[COEF_WIDTH-1:0] : yr[COEF_WIDTH-1:0];
  end

  assign done_o = done_q;

endmodule

### rtl/epr_matrix.sv
// ----------------------------------------------------------------------------
// epr_matrix: builds both coefficient matrices from sines and cosines
// A sequencer walks the entries, one product per cycle through one multiplier.
// ----------------------------------------------------------------------------
module epr_matrix #(
  parameter int COEF_WIDTH = 18
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [COEF_WIDTH-1:0] sx_i, cx_i, sy_i, cy_i, sz_i, cz_i,
  output logic                         done_o,
  output logic signed [COEF_WIDTH-1:0] fwd_o [9],
  output logic signed [COEF_WIDTH-1:0] inv_o [9]
);
  import epr_pkg::*;

  localparam int F  = COEF_WIDTH - 2;
  localparam int PW = 2 * COEF_WIDTH + 2;
  localparam logic signed [PW-1:0] CMax = PW'((64'sd1 <<< (COEF_WIDTH-1)) - 1);
  localparam logic signed [PW-1:0] CMin = -CMax - 1;

  // products: p0 sx*sy, p1 cx*sy, then a mix of first and second level products
  logic [4:0] step_q;
  logic       busy_q, done_q;
  logic signed [PW-1:0] pr_q [16];
  logic signed [PW-1:0] ma, mb, prod;

  function automatic logic signed [COEF_WIDTH-1:0] sat(input logic signed [PW-1:0] v);
    if (v > CMax) return CMax[COEF_WIDTH-1:0];
    if (v < CMin) return CMin[COEF_WIDTH-1:0];
    return v[COEF_WIDTH-1:0];
  endfunction

  always_comb begin
    ma = '0;
    mb = '0;
    case (step_q)
      5'd0:  begin ma = PW'(sx_i); mb = PW'(sy_i); end
      5'd1:  begin ma = PW'(cx_i); mb = PW'(sy_i); end
      5'd2:  begin ma = PW'(cy_i); mb = PW'(cz_i); end
      5'd3:  begin ma = PW'(cy_i); mb = PW'(sz_i); end
      5'd4:  begin ma = pr_q[0];   mb = PW'(cz_i); end
      5'd5:  begin ma = PW'(cx_i); mb = PW'(sz_i); end
      5'd6:  begin ma = pr_q[0];   mb = PW'(sz_i); end
      5'd7:  begin ma = PW'(cx_i); mb = PW'(cz_i); end
      5'd8:  begin ma = PW'(sx_i); mb = PW'(cy_i); end
      5'd9:  begin ma = pr_q[1];   mb = PW'(cz_i); end
      5'd10: begin ma = PW'(sx_i); mb = PW'(sz_i); end
      5'd11: begin ma = pr_q[1];   mb = PW'(sz_i); end
      5'd12: begin ma = PW'(sx_i); mb = PW'(cz_i); end
      5'd13: begin ma = PW'(cx_i); mb = PW'(cy_i); end
      5'd14: begin ma = -PW'(cy_i); mb = PW'(sz_i); end
      5'd15: begin ma = -PW'(sx_i); mb = PW'(cy_i); end
      default: begin ma = '0; mb = '0; end
    endcase
    prod = (ma * mb + (PW'(1) <<< (F-1))) >>> F;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (step_q == 5'd15) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
        step_q <= step_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !start_i) pr_q[step_q[3:0]] <= prod;
  end

  assign done_o = done_q;

  always_comb begin
    fwd_o[0] = sat(pr_q[2]);
    fwd_o[1] = sat(pr_q[3]);
    fwd_o[2] = sat(-PW'(sy_i));
    fwd_o[3] = sat(pr_q[4] - pr_q[5]);
    fwd_o[4] = sat(pr_q[6] + pr_q[7]);
    fwd_o[5] = sat(pr_q[8]);
    fwd_o[6] = sat(pr_q[9] + pr_q[10]);
    fwd_o[7] = sat(pr_q[11] - pr_q[12]);
    fwd_o[8] = sat(pr_q[13]);
    inv_o[0] = sat(pr_q[2]);
    inv_o[1] = sat(pr_q[4] + pr_q[5]);
    inv_o[2] = sat(pr_q[9] - pr_q[10]);
    inv_o[3] = sat(pr_q[14]);
    inv_o[4] = sat(pr_q[7] - pr_q[6]);
    inv_o[5] = sat(pr_q[12] + pr_q[11]);
    inv_o[6] = sat(PW'(sy_i));
    inv_o[7] = sat(pr_q[15]);
    inv_o[8] = sat(pr_q[13]);
  end

endmodule

### rtl/epr_lane.sv
// ----------------------------------------------------------------------------
// epr_lane: one output coordinate, a three-term dot product
// Stage 1 registers the three products, stage 2 rounds and saturates.
// ----------------------------------------------------------------------------
module epr_lane #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 18
) (
  input  logic                          clk_i,
  input  logic                          en1_i,
  input  logic                          en2_i,
  input  logic signed [COEF_WIDTH-1:0]  m0_i, m1_i, m2_i,
  input  logic signed [COORD_WIDTH-1:0] p0_i, p1_i, p2_i,
  output logic signed [COORD_WIDTH-1:0] res_o,
  output logic                          sat_o
);
  localparam int F  = COEF_WIDTH - 2;
  localparam int PW = COORD_WIDTH + COEF_WIDTH;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] Max = SW'((65'sd1 <<< (COORD_WIDTH-1)) - 1);
  localparam logic signed [SW-1:0] Min = -Max - 1;

  logic signed [PW-1:0] a_q, b_q, c_q;
  logic signed [SW-1:0] s;

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      a_q <= PW'(m0_i) * PW'(p0_i);
      b_q <= PW'(m1_i) * PW'(p1_i);
      c_q <= PW'(m2_i) * PW'(p2_i);
    end
  end

  assign s = (SW'(a_q) + SW'(b_q) + SW'(c_q) + (SW'(1) <<< (F-1))) >>> F;

  always_ff @(posedge clk_i) begin
    if (en2_i) begin
      sat_o <= (s > Max) || (s < Min);
      res_o <= (s > Max) ? Max[COORD_WIDTH-1:0] :
               (s < Min) ? Min[COORD_WIDTH-1:0] : s[COORD_WIDTH-1:0];
    end
  end

endmodule

### rtl/euler_point_rotation.sv
// ----------------------------------------------------------------------------
// euler_point_rotation: rotates a stream of 3D points by cached Euler matrices
// Products are registered, then the rounded result; throughput one point per cycle
//   when not stalled or rebuilding, set by three parallel dot-product lanes with a two-stage pipe.
// A write to an angle register rebuilds the matrices: CORDIC runs for X, Y and Z in turn,
//   then the matrix sequencer; no request is taken during the rebuild.
// Reset: async, active low; matrices reset to exact identity, pipe empty.
// ----------------------------------------------------------------------------
module euler_point_rotation #(
  parameter int COORD_WIDTH = 32,
  parameter int COEF_WIDTH  = 18,
  parameter int TRIG_STEPS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tdata: point_x, point_y, point_z (low to high), zero padded
  input  logic [((3*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  // tuser: req_type
  input  logic                          s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: rot_x, rot_y, rot_z (low to high), zero padded
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // tuser: saturated
  output logic                          m_axis_tuser,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [15:0]                   cfg_data_i
);
  import epr_pkg::*;

  localparam int DW = ((3*COORD_WIDTH+7)/8)*8;
  localparam logic signed [COEF_WIDTH-1:0] One = COEF_WIDTH'(1) <<< (COEF_WIDTH-2);

  // --- configuration and rebuild sequencer ---
  logic [15:0] ang_q [3];
  logic [1:0]  axis_q;
  logic        trig_go_q, mat_go_q, rebuild_q, built_q;
  logic        trig_done, mat_done;
  logic signed [COEF_WIDTH-1:0] s_q [3], c_q [3], ts, tc;
  logic signed [COEF_WIDTH-1:0] fwd [9], inv [9];
  logic [15:0] ang_sel;

  assign ang_sel = ang_q[axis_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) ang_q[k] <= '0;
      axis_q    <= '0;
      trig_go_q <= 1'b0;
      mat_go_q  <= 1'b0;
      rebuild_q <= 1'b0;
      built_q   <= 1'b0;
    end else begin
      trig_go_q <= 1'b0;
      mat_go_q  <= 1'b0;
      // start a rebuild on a write to a real angle register
      if (cfg_we_i && cfg_idx_i <= RegAngleZ) begin
        ang_q[cfg_idx_i] <= cfg_data_i;
        axis_q    <= RegAngleX;
        trig_go_q <= 1'b1;
        rebuild_q <= 1'b1;
      end else if (trig_done) begin
        if (axis_q == RegAngleZ) begin
          mat_go_q <= 1'b1;
        end else begin
          axis_q    <= axis_q + 2'd1;
          trig_go_q <= 1'b1;
        end
      end else if (mat_done) begin
        rebuild_q <= 1'b0;
        built_q   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (trig_done) begin
      s_q[axis_q] <= ts;
      c_q[axis_q] <= tc;
    end
  end

  epr_trig #(.COEF_WIDTH(COEF_WIDTH), .TRIG_STEPS(TRIG_STEPS)) u_trig (
    .clk_i, .rst_ni, .start_i(trig_go_q), .angle_i(ang_sel),
    .done_o(trig_done), .sin_o(ts), .cos_o(tc)
  );

  epr_matrix #(.COEF_WIDTH(COEF_WIDTH)) u_matrix (
    .clk_i, .rst_ni, .start_i(mat_go_q),
    .sx_i(s_q[0]), .cx_i(c_q[0]), .sy_i(s_q[1]), .cy_i(c_q[1]),
    .sz_i(s_q[2]), .cz_i(c_q[2]),
    .done_o(mat_done), .fwd_o(fwd), .inv_o(inv)
  );

  // --- pipeline control: two stages, stall on output backpressure ---
  logic v1_q, v2_q, adv2, adv1;
  assign adv2 = !v2_q || m_axis_tready;
  assign adv1 = adv2;
  assign s_axis_tready = adv1 && !rebuild_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= s_axis_tvalid && s_axis_tready;
      if (adv2) v2_q <= v1_q;
    end
  end

  // select the matrix; identity until the first rebuild completes
  logic signed [COEF_WIDTH-1:0] m [9];
  logic signed [COORD_WIDTH-1:0] p [3];
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      if (!built_q) m[k] = (k % 4 == 0) ? One : '0;
      else m[k] = s_axis_tuser ? inv[k] : fwd[k];
    end
    for (int j = 0; j < 3; j++) p[j] = s_axis_tdata[j*COORD_WIDTH +: COORD_WIDTH];
  end

  logic signed [COORD_WIDTH-1:0] res [3];
  logic [2:0] sat;

  for (genvar r = 0; r < 3; r++) begin : g_lane
    epr_lane #(.COORD_WIDTH(COORD_WIDTH), .COEF_WIDTH(COEF_WIDTH)) u_lane (
      .clk_i, .en1_i(adv1), .en2_i(adv2 && v1_q),
      .m0_i(m[3*r]), .m1_i(m[3*r+1]), .m2_i(m[3*r+2]),
      .p0_i(p[0]), .p1_i(p[1]), .p2_i(p[2]),
      .res_o(res[r]), .sat_o(sat[r])
    );
  end

  // merge the lanes
  assign m_axis_tvalid = v2_q;
  assign m_axis_tuser  = |sat;
  assign m_axis_tdata  = DW'({res[2], res[1], res[0]});

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the Euler point rotator
// Drives point requests in random bursts, stalls the result side on its own
// pattern, and checks every result against an in-bench fixed-point predictor
// of the CORDIC trig, the cached matrices and the saturating dot products.
// ----------------------------------------------------------------------------
module tb_top;
  import epr_pkg::*;

  localparam int CW  = 32;
  localparam int KW  = 18;
  localparam int KF  = KW - 2;
  localparam int NST = 16;
  localparam int DW  = ((3*CW+7)/8)*8;
  localparam int NRND = 1950;
  localparam longint CycLimit = 2000000;

  typedef struct packed {
    logic        kind;
    logic [31:0] px, py, pz;
  } point_req_t;

  typedef struct packed {
    logic [31:0] rx, ry, rz;
    logic        sat;
  } rot_res_t;

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0, s_axis_tready;
  logic [DW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid, m_axis_tready = 1'b0, m_axis_tuser;
  logic [DW-1:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;

  euler_point_rotation dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // predictor state: angles and both cached matrices
  logic [15:0] ang [3];
  longint fwd_m [9], inv_m [9];
  point_req_t pending_q [$];
  rot_res_t   rot_expect_q [$];
  int errors = 0, n_sent = 0, n_checked = 0, n_sat = 0;
  longint cycles = 0;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clip_coef(longint v);
    longint hi = (64'sd1 <<< (KW-1)) - 1;
    return v > hi ? hi : (v < -hi-1 ? -hi-1 : v);
  endfunction

  function automatic longint qmul(longint a, longint b);
    return asr(a*b + (64'sd1 <<< (KF-1)), KF);
  endfunction

  task automatic trig_of(input logic [15:0] raw, output longint s, output longint c);
    longint z, x, y, nx, at;
    bit neg;
    int d;
    z = longint'($signed(raw)) * 2048;
    x = 10188014; y = 0; neg = 0; d = 24 - KF;
    if (z > 26353589) begin z -= 52707179; neg = 1; end
    else if (z < -26353589) begin z += 52707179; neg = 1; end
    for (int i = 0; i < NST && i < 24; i++) begin
      case (i)
        0: at = 13176795; 1: at = 7778716; 2: at = 4110060; 3: at = 2086331;
        4: at = 1047214;  5: at = 524117;  6: at = 262123;  7: at = 131069;
        default: at = 64'sd65536 >>> (i-8);
      endcase
      if (z >= 0) begin
        nx = x - asr(y, i); y = y + asr(x, i); z -= at;
      end else begin
        nx = x + asr(y, i); y = y - asr(x, i); z += at;
      end
      x = nx;
    end
    if (neg) begin x = -x; y = -y; end
    c = clip_coef(asr(x + (64'sd1 <<< (d-1)), d));
    s = clip_coef(asr(y + (64'sd1 <<< (d-1)), d));
  endtask

  task automatic rebuild_matrices();
    longint sx, cx, sy, cy, sz, cz;
    trig_of(ang[0], sx, cx);
    trig_of(ang[1], sy, cy);
    trig_of(ang[2], sz, cz);
    fwd_m[0] = qmul(cy, cz);
    fwd_m[1] = qmul(cy, sz);
    fwd_m[2] = -sy;
    fwd_m[3] = qmul(qmul(sx, sy), cz) - qmul(cx, sz);
    fwd_m[4] = qmul(qmul(sx, sy), sz) + qmul(cx, cz);
    fwd_m[5] = qmul(sx, cy);
    fwd_m[6] = qmul(qmul(cx, sy), cz) + qmul(sx, sz);
    fwd_m[7] = qmul(qmul(cx, sy), sz) - qmul(sx, cz);
    fwd_m[8] = qmul(cx, cy);
    inv_m[0] = qmul(cy, cz);
    inv_m[1] = qmul(qmul(sx, sy), cz) + qmul(cx, sz);
    inv_m[2] = qmul(qmul(cx, sy), cz) - qmul(sx, sz);
    inv_m[3] = qmul(-cy, sz);
    inv_m[4] = qmul(cx, cz) - qmul(qmul(sx, sy), sz);
    inv_m[5] = qmul(sx, cz) + qmul(qmul(cx, sy), sz);
    inv_m[6] = sy;
    inv_m[7] = qmul(-sx, cy);
    inv_m[8] = qmul(cx, cy);
    for (int i = 0; i < 9; i++) begin
      fwd_m[i] = clip_coef(fwd_m[i]);
      inv_m[i] = clip_coef(inv_m[i]);
    end
  endtask

  // Exact row products fit in 64 bits: 18-bit coef times 32-bit coord, three terms.
  function automatic rot_res_t rotate_point(point_req_t r);
    rot_res_t o;
    longint p [3], acc, maxv, minv, v;
    logic [31:0] lane [3];
    maxv = (64'sd1 <<< (CW-1)) - 1;
    minv = -maxv - 1;
    p[0] = longint'($signed(r.px));
    p[1] = longint'($signed(r.py));
    p[2] = longint'($signed(r.pz));
    o.sat = 1'b0;
    for (int row = 0; row < 3; row++) begin
      acc = 64'sd1 <<< (KF-1);
      for (int j = 0; j < 3; j++)
        acc += (r.kind ? inv_m[row*3+j] : fwd_m[row*3+j]) * p[j];
      v = asr(acc, KF);
      if (v > maxv) begin v = maxv; o.sat = 1'b1; end
      else if (v < minv) begin v = minv; o.sat = 1'b1; end
      lane[row] = v[31:0];
    end
    o.rx = lane[0]; o.ry = lane[1]; o.rz = lane[2];
    return o;
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    errors++;
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_checked);
  endtask

  // Sender: bursts of random length with random gaps; hold request until taken.
  int burst_left = 0, gap_left = 0;
  bit drv_en = 0;
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
    if (drv_en) begin
      if (!(s_axis_tvalid && !s_axis_tready)) begin
        // previous request is done (or none)
        if (s_axis_tvalid) begin
          rot_expect_q.push_back(rotate_point(pending_q.pop_front()));
          n_sent++;
        end
        if (gap_left > 0) gap_left--;
        if (pending_q.size() > 0 && gap_left == 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {pending_q[0].pz, pending_q[0].py, pending_q[0].px};
          s_axis_tuser  <= pending_q[0].kind;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else burst_left--;
        end else s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern of its own, with long no-stall stretches.
  int stall_mode = 0;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= $urandom_range(0, 1);
      2: m_axis_tready <= ($urandom_range(0, 4) == 0);
      default: m_axis_tready <= (cycles % 3 != 0);
    endcase
  end

  // Monitor: compare each taken result with the oldest expectation.
  rot_res_t want_r;
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (rot_expect_q.size() == 0) begin
        report("unexpected result", m_axis_tdata[31:0], '0);
      end else begin
        want_r = rot_expect_q.pop_front();
        if (m_axis_tdata[31:0] !== want_r.rx) report("rot_x", m_axis_tdata[31:0], want_r.rx);
        if (m_axis_tdata[63:32] !== want_r.ry) report("rot_y", m_axis_tdata[63:32], want_r.ry);
        if (m_axis_tdata[95:64] !== want_r.rz) report("rot_z", m_axis_tdata[95:64], want_r.rz);
        if (m_axis_tuser !== want_r.sat) report("saturated", m_axis_tuser, want_r.sat);
        if (want_r.sat) n_sat++;
      end
      n_checked++;
    end
  end

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      2: return {{12{$urandom_range(0,1) == 1}}, 20'($urandom())};
      3: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 65535*64)) - 65535*32);
    endcase
  endfunction

  function automatic point_req_t rnd_point();
    point_req_t r;
    r.kind = $urandom_range(0, 1);
    r.px = rnd_coord(); r.py = rnd_coord(); r.pz = rnd_coord();
    return r;
  endfunction

  // Drain everything, then give a pending rebuild time to settle.
  task automatic drain();
    while (pending_q.size() > 0 || s_axis_tvalid || rot_expect_q.size() > 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // Write one angle register at idle; index 3 exercises the ignored slot.
  task automatic write_angle(input logic [1:0] idx, input logic [15:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx <= RegAngleZ) begin
      ang[idx] = v;
      rebuild_matrices();
    end
    // requests stall on tready during the rebuild anyway
    repeat (3*NST + 40) @(posedge clk_i);
  endtask

  task automatic queue_directed();
    logic [31:0] ext [6] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0001_0000,
                             32'hffff_ffff, 32'h0000_8000};
    point_req_t r;
    for (int i = 0; i < 6; i++) begin
      r.kind = i[0]; r.px = ext[i]; r.py = ext[(i+1)%6]; r.pz = ext[(i+3)%6];
      pending_q.push_back(r);
      r.kind = ~i[0]; r.px = ext[i]; r.py = ext[i]; r.pz = ext[i];
      pending_q.push_back(r);
    end
  endtask

  logic [15:0] ang_set [8] = '{16'd0, 16'd25736, -16'sd25736, 16'd12868, 16'h7fff,
                               16'h8000, 16'd6434, -16'sd19000};

  initial begin
    int phases;
    ang = '{default: '0};
    for (int i = 0; i < 9; i++) begin
      fwd_m[i] = (i % 4 == 0) ? (64'sd1 <<< KF) : 0;
      inv_m[i] = fwd_m[i];
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    drv_en = 1;
    // identity matrices straight out of reset
    queue_directed();
    drain();
    // written zeros give CORDIC values, not exact identity
    write_angle(RegAngleX, 16'd0);
    queue_directed();
    drain();
    // the unused register slot must not disturb the matrices
    write_angle(2'd3, 16'h1234);
    queue_directed();
    drain();
    phases = 10;
    for (int ph = 0; ph < phases; ph++) begin
      for (int a = 0; a < 3; a++)
        write_angle(a[1:0], (ph < 4) ? ang_set[(ph*3+a)%8] : 16'($urandom()));
      repeat (NRND / phases) pending_q.push_back(rnd_point());
      drain();
    end
    drv_en = 0;
    repeat (20) @(posedge clk_i);
    $display("checked %0d rotated points over %0d angle settings, %0d saturated",
             n_checked, phases + 3, n_sat);
    if (errors == 0 && rot_expect_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors, %0d results missing", errors, rot_expect_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/epr_pkg.sv
rtl/epr_trig.sv
rtl/epr_matrix.sv
rtl/epr_lane.sv
rtl/euler_point_rotation.sv
verif/tb_top.sv
